>>> design/cmns_pkg.sv
// Shared types and constants of the contact map neighbour search block.
// Used by every module of the design folder; depends on nothing else.
package cmns_pkg;

    // Field widths of the stream words and of the configuration registers.
    localparam int IDX_W     = 6;
    localparam int COORD_W   = 20;
    localparam int CHAIN_W   = 8;
    localparam int RES_W     = 16;
    localparam int DSQ_W     = 42;
    localparam int CNT_W     = 7;
    localparam int CFG_IDX_W = 1;

    // Internal arithmetic widths.
    localparam int DIFF_W    = COORD_W + 1;   // coordinate difference
    localparam int SQ_W      = 2 * COORD_W + 1; // one squared difference
    localparam int RDIFF_W   = RES_W + 1;     // residue difference
    localparam int IDX_EXT_W = 13;            // holds any slot count up to 4096

    // Input word layout, lowest bit first.
    localparam int IN_TDATA_W   = 96;
    localparam int IN_IDX_LSB   = 0;
    localparam int IN_X_LSB     = IN_IDX_LSB + IDX_W;
    localparam int IN_Y_LSB     = IN_X_LSB + COORD_W;
    localparam int IN_Z_LSB     = IN_Y_LSB + COORD_W;
    localparam int IN_CHAIN_LSB = IN_Z_LSB + COORD_W;
    localparam int IN_RES_LSB   = IN_CHAIN_LSB + CHAIN_W;

    // Output word layout, lowest bit first.
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_IDX_LSB = 0;
    localparam int OUT_DSQ_LSB = OUT_IDX_LSB + IDX_W;

    // Operation codes carried in the input tuser.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_SQ = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ATOM_COUNT   = 1'b1;

    // One stored atom.
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [CHAIN_W-1:0] chain;
        logic [RES_W-1:0]   res;
    } t_atom;

    // A classified command passed from the front end to the back end.
    typedef struct packed {
        logic             op;
        logic             idx_ok;
        logic [IDX_W-1:0] idx;
        t_atom            atom;
    } t_cmd;

    // Queue status seen by both ends.
    typedef struct packed {
        logic full;
        logic empty;
    } t_qstat;

endpackage

>>> design/contact_map_neighbor_search_top.sv
// Top level of the contact map neighbour search block.
// Depends on cmns_pkg, cmns_front, cmns_queue and cmns_back.
//
//   channel   direction  handshake                    payload
//   s_axis    in         s_axis_tvalid/s_axis_tready  tdata: load or query word, tuser: op
//   m_axis    out        m_axis_tvalid/m_axis_tready  tdata: neighbour, tuser: found, tlast
//   cfg       in         i_cfg_we (no wait)           i_cfg_index, i_cfg_data
//
// A load word is written to the atom store as it is popped. A query reads
// the centre atom, then min(atom_count, MAX_ATOMS, 64) stored atoms one a
// cycle, while the output is not stalled, via the single read port of the
// atom store into the four-stage distance pipeline. Reset is synchronous and
// active low; it clears the configuration registers and all control state
// but not the atom store, whose slots must be loaded before they are read.
// A stalled output holds the whole scan pipeline; the front end keeps taking
// words until its register and the two-entry command queue are full.
module contact_map_neighbor_search_top #(
    parameter int MAX_ATOMS = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Input word, from the lowest bit up: atom_index, coord_x, coord_y,
    // coord_z, chain_id, residue_pos, six zero bits.
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [cmns_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // Input tuser: operation.
    input  logic                                  s_axis_tuser,
    // Output word, from the lowest bit up: neighbor_index, dist_sq.
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [cmns_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // Output tuser: found.
    output logic                                  m_axis_tuser,
    output logic                                  m_axis_tlast,
    // Configuration writes.
    input  logic                                  i_cfg_we,
    input  logic [cmns_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [cmns_pkg::DSQ_W-1:0]            i_cfg_data
);

    // The scan never covers more slots than the store holds or than the
    // neighbour index can name.
    localparam int SCAN_CAP = (MAX_ATOMS < 64) ? MAX_ATOMS : 64;

    logic [cmns_pkg::DSQ_W-1:0] r_threshold_sq;
    logic [cmns_pkg::CNT_W-1:0] r_atom_count;
    logic [cmns_pkg::CNT_W-1:0] w_limit;

    logic                       w_push;
    logic                       w_pop;
    cmns_pkg::t_cmd             w_front_cmd;
    cmns_pkg::t_cmd             w_queue_cmd;
    cmns_pkg::t_qstat           w_qstat;

    logic [cmns_pkg::IDX_W-1:0] w_res_index;
    logic [cmns_pkg::DSQ_W-1:0] w_res_dsq;

    // Configuration registers; users write only while the block is idle (unchecked).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold_sq <= '0;
            r_atom_count   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cmns_pkg::CFG_THRESHOLD_SQ: r_threshold_sq <= i_cfg_data;
                cmns_pkg::CFG_ATOM_COUNT:
                    r_atom_count <= i_cfg_data[cmns_pkg::CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Counts above the cap saturate.
    assign w_limit = (r_atom_count > cmns_pkg::CNT_W'(SCAN_CAP))
                   ? cmns_pkg::CNT_W'(SCAN_CAP) : r_atom_count;

    // The front end registers and classifies each word.
    cmns_front #(
        .MAX_ATOMS (MAX_ATOMS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .o_push        (w_push),
        .o_cmd         (w_front_cmd),
        .i_qstat       (w_qstat)
    );

    // The queue lets the front end run ahead of a long query.
    cmns_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_queue_cmd),
        .o_qstat (w_qstat)
    );

    // The back end owns the atom store and produces the result words.
    cmns_back #(
        .MAX_ATOMS (MAX_ATOMS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_queue_cmd),
        .i_qstat        (w_qstat),
        .o_pop          (w_pop),
        .i_threshold_sq (r_threshold_sq),
        .i_limit        (w_limit),
        .o_res_valid    (m_axis_tvalid),
        .i_res_ready    (m_axis_tready),
        .o_res_found    (m_axis_tuser),
        .o_res_index    (w_res_index),
        .o_res_dsq      (w_res_dsq),
        .o_res_last     (m_axis_tlast)
    );

    assign m_axis_tdata = {w_res_dsq, w_res_index};

`ifndef NO_ASSERTIONS
    // A word that names no neighbour always closes its query.
    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("no-neighbour word without tlast");

    // A word that does not close its query names a neighbour.
    a_mid_is_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser)
        else $error("word inside a query without found");

    // The queue can never look full and empty at once.
    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_qstat.full && w_qstat.empty))
        else $error("command queue status inconsistent");
`endif

endmodule

>>> design/cmns_front.sv
// Front end: takes input words, unpacks and classifies them into commands.
// Depends on cmns_pkg; feeds cmns_queue.
module cmns_front #(
    parameter int MAX_ATOMS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [cmns_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                             s_axis_tuser,
    output logic                             o_push,
    output cmns_pkg::t_cmd                   o_cmd,
    input  cmns_pkg::t_qstat                 i_qstat
);

    logic           r_valid;
    cmns_pkg::t_cmd r_cmd;
    cmns_pkg::t_cmd n_cmd;
    logic [cmns_pkg::IDX_EXT_W-1:0] w_idx_ext;

    assign o_push        = r_valid && !i_qstat.full;
    assign s_axis_tready = !r_valid || !i_qstat.full;
    assign o_cmd         = r_cmd;

    always_comb begin
        w_idx_ext = {{(cmns_pkg::IDX_EXT_W - cmns_pkg::IDX_W){1'b0}},
                     s_axis_tdata[cmns_pkg::IN_IDX_LSB +: cmns_pkg::IDX_W]};
        n_cmd.op         = s_axis_tuser;
        n_cmd.idx        = s_axis_tdata[cmns_pkg::IN_IDX_LSB +: cmns_pkg::IDX_W];
        // Slots beyond the store are dropped on load and answer empty on query.
        n_cmd.idx_ok     = w_idx_ext < cmns_pkg::IDX_EXT_W'(MAX_ATOMS);
        n_cmd.atom.x     = s_axis_tdata[cmns_pkg::IN_X_LSB +: cmns_pkg::COORD_W];
        n_cmd.atom.y     = s_axis_tdata[cmns_pkg::IN_Y_LSB +: cmns_pkg::COORD_W];
        n_cmd.atom.z     = s_axis_tdata[cmns_pkg::IN_Z_LSB +: cmns_pkg::COORD_W];
        n_cmd.atom.chain = s_axis_tdata[cmns_pkg::IN_CHAIN_LSB +: cmns_pkg::CHAIN_W];
        n_cmd.atom.res   = s_axis_tdata[cmns_pkg::IN_RES_LSB +: cmns_pkg::RES_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

>>> design/cmns_queue.sv
// Two-entry command queue between the front and back ends.
// Depends on cmns_pkg.
module cmns_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  cmns_pkg::t_cmd   i_cmd,
    input  logic             i_pop,
    output cmns_pkg::t_cmd   o_cmd,
    output cmns_pkg::t_qstat o_qstat
);

    cmns_pkg::t_cmd r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic           w_push;
    logic           w_pop;

    assign o_qstat.full  = r_count == 2'd2;
    assign o_qstat.empty = r_count == 2'd0;
    assign w_push        = i_push && !o_qstat.full;
    assign w_pop         = i_pop && !o_qstat.empty;
    assign o_cmd         = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> design/cmns_back.sv
// Back end: atom store, scan sequencer, distance pipeline and result register.
// Depends on cmns_pkg; takes commands from cmns_queue.
module cmns_back #(
    parameter int MAX_ATOMS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  cmns_pkg::t_cmd                  i_cmd,
    input  cmns_pkg::t_qstat                i_qstat,
    output logic                            o_pop,
    input  logic [cmns_pkg::DSQ_W-1:0]      i_threshold_sq,
    input  logic [cmns_pkg::CNT_W-1:0]      i_limit,
    output logic                            o_res_valid,
    input  logic                            i_res_ready,
    output logic                            o_res_found,
    output logic [cmns_pkg::IDX_W-1:0]      o_res_index,
    output logic [cmns_pkg::DSQ_W-1:0]      o_res_dsq,
    output logic                            o_res_last
);

    localparam int AW = $clog2(MAX_ATOMS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CTR   = 3'd1;
    localparam logic [2:0] S_CAP   = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_END   = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;

    cmns_pkg::t_atom r_mem [MAX_ATOMS];
    cmns_pkg::t_atom r_rd_data;
    cmns_pkg::t_atom r_ctr;

    logic [2:0]                    r_state;
    logic [AW-1:0]                 r_ctr_addr;
    logic [cmns_pkg::IDX_W-1:0]    r_j;

    logic                          w_advance;
    logic                          w_rd_en;
    logic [AW-1:0]                 w_rd_addr;
    logic [AW-1:0]                 w_cmd_addr;
    logic [AW-1:0]                 w_scan_addr;
    logic [cmns_pkg::IDX_EXT_W-1:0] w_cmd_ext;
    logic [cmns_pkg::IDX_EXT_W-1:0] w_scan_ext;
    logic                          w_scan_done;

    // Pipeline tokens: v marks a stored atom, e the end of the scan.
    logic r_v0, r_e0, r_v1, r_e1, r_v2, r_e2, r_v3, r_e3;
    logic [cmns_pkg::IDX_W-1:0] r_j0, r_j1, r_j2, r_j3;
    logic r_ok1, r_ok2, r_ok3;

    logic signed [cmns_pkg::DIFF_W-1:0]  r_dx, r_dy, r_dz;
    logic signed [cmns_pkg::DIFF_W-1:0]  w_dx, w_dy, w_dz;
    logic signed [cmns_pkg::RDIFF_W-1:0] w_dr;
    logic                                w_ok;
    logic signed [2*cmns_pkg::DIFF_W-1:0] w_px, w_py, w_pz;
    logic [cmns_pkg::SQ_W-1:0]           r_sqx, r_sqy, r_sqz;
    logic [cmns_pkg::DSQ_W-1:0]          r_dsq3;

    logic                          w_hit;
    logic                          r_hold_v;
    logic [cmns_pkg::IDX_W-1:0]    r_hold_j;
    logic [cmns_pkg::DSQ_W-1:0]    r_hold_dsq;
    logic                          r_out_valid;

    assign w_advance   = !r_out_valid || i_res_ready;
    assign o_pop       = (r_state == S_IDLE) && !i_qstat.empty;
    assign w_cmd_ext   = {{(cmns_pkg::IDX_EXT_W - cmns_pkg::IDX_W){1'b0}}, i_cmd.idx};
    assign w_scan_ext  = {{(cmns_pkg::IDX_EXT_W - cmns_pkg::IDX_W){1'b0}}, r_j};
    assign w_cmd_addr  = w_cmd_ext[AW-1:0];
    assign w_scan_addr = w_scan_ext[AW-1:0];
    assign w_rd_en     = (r_state == S_CTR) || ((r_state == S_SCAN) && w_advance);
    assign w_rd_addr   = (r_state == S_CTR) ? r_ctr_addr : w_scan_addr;
    assign w_scan_done = {1'b0, r_j} == (i_limit - cmns_pkg::CNT_W'(1));

    // Atom store: one write port for loads, one registered read port.
    always_ff @(posedge i_clk) begin
        if (o_pop && (i_cmd.op == cmns_pkg::OP_LOAD) && i_cmd.idx_ok) begin
            r_mem[w_cmd_addr] <= i_cmd.atom;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (o_pop && (i_cmd.op == cmns_pkg::OP_QUERY)) begin
                        r_state <= i_cmd.idx_ok ? S_CTR : S_END;
                    end
                end
                S_CTR: begin
                    r_state <= S_CAP;
                end
                S_CAP: begin
                    r_state <= (i_limit == '0) ? S_END : S_SCAN;
                end
                S_SCAN: begin
                    if (w_advance && w_scan_done) begin
                        r_state <= S_END;
                    end
                end
                S_END: begin
                    if (w_advance) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    if (w_advance && r_e3) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ctr_addr <= w_cmd_addr;
        end
        if (r_state == S_CAP) begin
            r_ctr <= r_rd_data;
            r_j   <= '0;
        end else if ((r_state == S_SCAN) && w_advance) begin
            r_j <= r_j + cmns_pkg::IDX_W'(1);
        end
    end

    // Stage 1: coordinate and residue differences against the centre atom.
    always_comb begin
        w_dx = $signed({r_ctr.x[cmns_pkg::COORD_W-1], r_ctr.x})
             - $signed({r_rd_data.x[cmns_pkg::COORD_W-1], r_rd_data.x});
        w_dy = $signed({r_ctr.y[cmns_pkg::COORD_W-1], r_ctr.y})
             - $signed({r_rd_data.y[cmns_pkg::COORD_W-1], r_rd_data.y});
        w_dz = $signed({r_ctr.z[cmns_pkg::COORD_W-1], r_ctr.z})
             - $signed({r_rd_data.z[cmns_pkg::COORD_W-1], r_rd_data.z});
        w_dr = $signed({r_ctr.res[cmns_pkg::RES_W-1], r_ctr.res})
             - $signed({r_rd_data.res[cmns_pkg::RES_W-1], r_rd_data.res});
        w_ok = (r_ctr.chain != r_rd_data.chain)
            || (w_dr > cmns_pkg::RDIFF_W'(signed'(1)))
            || (w_dr < -cmns_pkg::RDIFF_W'(signed'(1)));
    end

    // Stage 2: three squares in parallel.
    assign w_px = r_dx * r_dx;
    assign w_py = r_dy * r_dy;
    assign w_pz = r_dz * r_dz;

    // Result stage: a hit is held back until the next hit or the end token so
    // that the last one of a query can be marked once the end token arrives.
    assign w_hit = r_v3 && r_ok3 && (r_dsq3 < i_threshold_sq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0; r_e0 <= 1'b0;
            r_v1 <= 1'b0; r_e1 <= 1'b0;
            r_v2 <= 1'b0; r_e2 <= 1'b0;
            r_v3 <= 1'b0; r_e3 <= 1'b0;
            r_hold_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_v0 <= r_state == S_SCAN;
            r_e0 <= r_state == S_END;
            r_v1 <= r_v0; r_e1 <= r_e0;
            r_v2 <= r_v1; r_e2 <= r_e1;
            r_v3 <= r_v2; r_e3 <= r_e2;
            if (w_hit) begin
                r_hold_v <= 1'b1;
            end else if (r_e3) begin
                r_hold_v <= 1'b0;
            end
            r_out_valid <= (w_hit && r_hold_v) || r_e3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_j0  <= r_j;
            r_j1  <= r_j0;
            r_ok1 <= w_ok;
            r_dx  <= w_dx;
            r_dy  <= w_dy;
            r_dz  <= w_dz;
            r_j2  <= r_j1;
            r_ok2 <= r_ok1;
            r_sqx <= w_px[cmns_pkg::SQ_W-1:0];
            r_sqy <= w_py[cmns_pkg::SQ_W-1:0];
            r_sqz <= w_pz[cmns_pkg::SQ_W-1:0];
            r_j3  <= r_j2;
            r_ok3 <= r_ok2;
            r_dsq3 <= {1'b0, r_sqx} + {1'b0, r_sqy} + {1'b0, r_sqz};
            if (w_hit) begin
                r_hold_j   <= r_j3;
                r_hold_dsq <= r_dsq3;
            end
            if (w_hit && r_hold_v) begin
                o_res_found <= 1'b1;
                o_res_index <= r_hold_j;
                o_res_dsq   <= r_hold_dsq;
                o_res_last  <= 1'b0;
            end else if (r_e3) begin
                o_res_found <= r_hold_v;
                o_res_index <= r_hold_v ? r_hold_j : '0;
                o_res_dsq   <= r_hold_v ? r_hold_dsq : '0;
                o_res_last  <= 1'b1;
            end
        end
    end

    assign o_res_valid = r_out_valid;

endmodule

>>> tb/neighbour_scoreboard.sv
`timescale 1ns / 100ps
// Scoreboard class for the contact map neighbour search testbench: it keeps its own
// copy of the atom store and registers, predicts every result word and checks them.
// Depends on cmns_pkg for the atom type and the register and operation codes.
package neighbour_scoreboard_pkg;

    localparam int STORE_SLOTS = 64;

    typedef struct packed {
        bit                       found;
        bit [cmns_pkg::IDX_W-1:0] index;
        bit [cmns_pkg::DSQ_W-1:0] dist_sq;
        bit                       last;
    } t_neighbour_hit;

    class neighbour_scoreboard;
        cmns_pkg::t_atom          atoms [STORE_SLOTS];
        bit [cmns_pkg::DSQ_W-1:0] cutoff_sq;
        bit [cmns_pkg::CNT_W-1:0] scan_count;
        t_neighbour_hit           expected_hits [$];
        int unsigned              mismatches;

        function new();
            foreach (atoms[k]) atoms[k] = '0;
            cutoff_sq  = '0;
            scan_count = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [cmns_pkg::CFG_IDX_W-1:0] idx,
                                bit [cmns_pkg::DSQ_W-1:0] value);
            if (idx == cmns_pkg::CFG_THRESHOLD_SQ) begin
                cutoff_sq = value;
            end else if (idx == cmns_pkg::CFG_ATOM_COUNT) begin
                scan_count = value[cmns_pkg::CNT_W-1:0];
            end
        endfunction

        function int pending();
            return expected_hits.size();
        endfunction

        // Notes one accepted input word: a load updates the store, a query
        // queues every neighbour that the scan is to report.
        function void note_word(logic op, bit [cmns_pkg::IDX_W-1:0] idx,
                                cmns_pkg::t_atom atom);
            int              limit;
            int              hits;
            int              dres;
            longint          dx, dy, dz, dsq;
            cmns_pkg::t_atom centre;
            t_neighbour_hit  hit;
            if (op == cmns_pkg::OP_LOAD) begin
                atoms[idx] = atom;
                return;
            end
            limit = (scan_count > STORE_SLOTS) ? STORE_SLOTS : int'(scan_count);
            centre = atoms[idx];
            hits = 0;
            for (int j = 0; j < limit; j++) begin
                dx = longint'($signed(centre.x)) - longint'($signed(atoms[j].x));
                dy = longint'($signed(centre.y)) - longint'($signed(atoms[j].y));
                dz = longint'($signed(centre.z)) - longint'($signed(atoms[j].z));
                dsq = dx * dx + dy * dy + dz * dz;
                dres = int'($signed(centre.res)) - int'($signed(atoms[j].res));
                if (dres < 0) begin
                    dres = -dres;
                end
                // Same chain needs a residue gap of at least two, which also
                // keeps the centre atom out of its own list.
                if (dsq < longint'(cutoff_sq) &&
                    (centre.chain != atoms[j].chain || dres > 1)) begin
                    hit.found   = 1'b1;
                    hit.index   = j[cmns_pkg::IDX_W-1:0];
                    hit.dist_sq = dsq[cmns_pkg::DSQ_W-1:0];
                    hit.last    = 1'b0;
                    expected_hits.push_back(hit);
                    hits++;
                end
            end
            if (hits == 0) begin
                hit = '0;
                hit.last = 1'b1;
                expected_hits.push_back(hit);
            end else begin
                expected_hits[expected_hits.size() - 1].last = 1'b1;
            end
        endfunction

        // Compares one accepted result word with the oldest expectation.
        function void check_result(bit found, bit [cmns_pkg::IDX_W-1:0] index,
                                   bit [cmns_pkg::DSQ_W-1:0] dist_sq, bit last);
            t_neighbour_hit want;
            if (expected_hits.size() == 0) begin
                $display("%0t: unexpected result found=%0b index=%0d dist_sq=%0d last=%0b",
                         $time, found, index, dist_sq, last);
                mismatches++;
                return;
            end
            want = expected_hits.pop_front();
            if (want.found != found) begin
                $display("%0t: found expected %0b actual %0b", $time, want.found, found);
                mismatches++;
            end
            if (want.index != index) begin
                $display("%0t: neighbor_index expected %0d actual %0d",
                         $time, want.index, index);
                mismatches++;
            end
            if (want.dist_sq != dist_sq) begin
                $display("%0t: dist_sq expected %0d actual %0d",
                         $time, want.dist_sq, dist_sq);
                mismatches++;
            end
            if (want.last != last) begin
                $display("%0t: last expected %0b actual %0b", $time, want.last, last);
                mismatches++;
            end
        endfunction
    endclass

endpackage

>>> tb/tb.sv
`timescale 1ns / 100ps
// Top of the contact map neighbour search testbench: clock, reset, word drivers,
// directed and random stimulus. Depends on cmns_pkg, neighbour_scoreboard_pkg and
// contact_map_neighbor_search_top.
module tb;

    localparam int SLOTS = neighbour_scoreboard_pkg::STORE_SLOTS;
    // A margin after the last result word has left, so that any trailing load
    // can settle before registers change.
    localparam int QUIET_CYCLES = 100;
    localparam bit [cmns_pkg::DSQ_W-1:0] MAX_CUTOFF = {cmns_pkg::DSQ_W{1'b1}};

    logic                             i_clk;
    logic                             i_rst_n = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [cmns_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                             s_axis_tuser = cmns_pkg::OP_LOAD;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [cmns_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             m_axis_tuser;
    logic                             m_axis_tlast;
    logic                             i_cfg_we = 1'b0;
    logic [cmns_pkg::CFG_IDX_W-1:0]   i_cfg_index = cmns_pkg::CFG_THRESHOLD_SQ;
    logic [cmns_pkg::DSQ_W-1:0]       i_cfg_data = '0;

    // Chance, in per cent, that the sender or the receiver idles in a cycle.
    int tx_idle_pct = 18;
    int rx_idle_pct = 56;

    // Centre of the cluster that most random atoms fall into, so that
    // queries find a useful number of neighbours.
    int cluster_x, cluster_y, cluster_z;

    neighbour_scoreboard_pkg::neighbour_scoreboard sb = new();

    contact_map_neighbor_search_top #(
        .MAX_ATOMS(SLOTS)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Result side: the outputs are sampled at the edge, before this edge's
    // updates land, and the ready for the next cycle is drawn afresh.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tuser,
                            m_axis_tdata[cmns_pkg::OUT_IDX_LSB +: cmns_pkg::IDX_W],
                            m_axis_tdata[cmns_pkg::OUT_DSQ_LSB +: cmns_pkg::DSQ_W],
                            m_axis_tlast);
        end
        m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Offers one word and returns at the edge where it is taken. The valid
    // is left high so that back-to-back words need no second assignment.
    task automatic send_word(input logic op, input bit [cmns_pkg::IDX_W-1:0] idx,
                             input cmns_pkg::t_atom atom);
        logic [cmns_pkg::IN_TDATA_W-1:0] word;
        word = '0;
        word[cmns_pkg::IN_IDX_LSB   +: cmns_pkg::IDX_W]   = idx;
        word[cmns_pkg::IN_X_LSB     +: cmns_pkg::COORD_W] = atom.x;
        word[cmns_pkg::IN_Y_LSB     +: cmns_pkg::COORD_W] = atom.y;
        word[cmns_pkg::IN_Z_LSB     +: cmns_pkg::COORD_W] = atom.z;
        word[cmns_pkg::IN_CHAIN_LSB +: cmns_pkg::CHAIN_W] = atom.chain;
        word[cmns_pkg::IN_RES_LSB   +: cmns_pkg::RES_W]   = atom.res;
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= op;
        do begin
            @(posedge i_clk);
        end while (s_axis_tready !== 1'b1);
        sb.note_word(op, idx, atom);
    endtask

    task automatic load_atom(input int idx, input int x, input int y, input int z,
                             input int chain, input int res);
        cmns_pkg::t_atom atom;
        atom.x     = x[cmns_pkg::COORD_W-1:0];
        atom.y     = y[cmns_pkg::COORD_W-1:0];
        atom.z     = z[cmns_pkg::COORD_W-1:0];
        atom.chain = chain[cmns_pkg::CHAIN_W-1:0];
        atom.res   = res[cmns_pkg::RES_W-1:0];
        send_word(cmns_pkg::OP_LOAD, idx[cmns_pkg::IDX_W-1:0], atom);
    endtask

    // The atom fields of a query carry noise: the block must ignore them.
    task automatic query(input int idx);
        logic [cmns_pkg::IN_TDATA_W-1:0] noise;
        cmns_pkg::t_atom                 junk;
        noise = {$urandom, $urandom, $urandom};
        junk  = noise[$bits(cmns_pkg::t_atom)-1:0];
        send_word(cmns_pkg::OP_QUERY, idx[cmns_pkg::IDX_W-1:0], junk);
    endtask

    // Mostly atoms near the cluster centre on a few chains with close
    // residue numbers, so that chain and residue rules both matter; the
    // rest are fully random and exercise every bit of every field.
    task automatic load_random_atom(input int idx);
        if ($urandom_range(0, 99) < 20) begin
            load_atom(idx, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            load_atom(idx,
                      cluster_x + int'($urandom_range(0, 2048)) - 1024,
                      cluster_y + int'($urandom_range(0, 2048)) - 1024,
                      cluster_z + int'($urandom_range(0, 2048)) - 1024,
                      65 + int'($urandom_range(0, 2)), $urandom_range(0, 24));
        end
    endtask

    task automatic wait_quiet();
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    // Registers change only once the block has drained every word.
    task automatic apply_setting(input bit [cmns_pkg::DSQ_W-1:0] cutoff,
                                 input bit [cmns_pkg::CNT_W-1:0] count);
        s_axis_tvalid <= 1'b0;
        wait_quiet();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= cmns_pkg::CFG_THRESHOLD_SQ;
        i_cfg_data  <= cutoff;
        @(posedge i_clk);
        sb.write_reg(cmns_pkg::CFG_THRESHOLD_SQ, cutoff);
        i_cfg_index <= cmns_pkg::CFG_ATOM_COUNT;
        i_cfg_data  <= cmns_pkg::DSQ_W'(count);
        @(posedge i_clk);
        sb.write_reg(cmns_pkg::CFG_ATOM_COUNT, cmns_pkg::DSQ_W'(count));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // A mix of loads to any slot and queries of any slot. Slots from
    // fill_from up are loaded first, so no query reads an empty slot.
    task automatic random_phase(input int n_items, input int fill_from);
        for (int k = fill_from; k < SLOTS; k++) begin
            load_random_atom(k);
        end
        repeat (n_items) begin
            if ($urandom_range(0, 99) < 40) begin
                load_random_atom($urandom_range(0, SLOTS - 1));
            end else begin
                query($urandom_range(0, SLOTS - 1));
            end
        end
    endtask

    initial begin : stimulus
        cluster_x = int'($urandom_range(0, 800000)) - 400000;
        cluster_y = int'($urandom_range(0, 800000)) - 400000;
        cluster_z = int'($urandom_range(0, 800000)) - 400000;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Straight after reset the count is zero, so a query finds nothing.
        load_atom(0, -524288, -524288, -524288, 0, -32768);
        load_atom(1, 524287, 524287, 524287, 255, 32767);
        query(0);

        // A small hand-built neighbourhood around slot 2: an adjacent residue
        // on the same chain, a residue two apart, another chain at one
        // angstrom, a coincident copy of the centre and a very close atom
        // on the neighbouring residue.
        apply_setting(MAX_CUTOFF, cmns_pkg::CNT_W'(8));
        load_atom(2, 0, 0, 0, 65, 10);
        load_atom(3, 256, 0, 0, 65, 11);
        load_atom(4, 0, 256, 0, 65, 12);
        load_atom(5, 0, 0, -256, 66, 11);
        load_atom(6, 0, 0, 0, 65, 10);
        load_atom(7, -1, -1, -1, 65, 9);
        load_atom(63, 1000, -1000, 500, 66, 300);
        // Slot 1 against slot 0 gives the largest possible distance.
        query(1);
        query(2);
        // A centre above the count still scans the counted slots.
        query(63);
        query(5);

        // A zero cutoff admits nothing; a cutoff equal to the distance is
        // still too tight, one more lets the one-angstrom atoms in.
        apply_setting('0, cmns_pkg::CNT_W'(8));
        query(2);
        apply_setting(42'd65536, cmns_pkg::CNT_W'(8));
        query(2);
        apply_setting(42'd65537, cmns_pkg::CNT_W'(8));
        query(2);
        query(6);

        // Random part: fill the store, then several settings under each
        // pattern of idling, with the full store and a saturating count.
        apply_setting(cmns_pkg::DSQ_W'($urandom_range(2000000, 12000000)),
                      cmns_pkg::CNT_W'(SLOTS));
        random_phase(20, 8);
        apply_setting(MAX_CUTOFF, 7'd127);
        random_phase(10, SLOTS);

        tx_idle_pct = 56;
        rx_idle_pct = 18;
        apply_setting(cmns_pkg::DSQ_W'($urandom_range(0, 16000000)),
                      cmns_pkg::CNT_W'($urandom_range(1, SLOTS - 1)));
        random_phase(20, SLOTS);
        apply_setting(cmns_pkg::DSQ_W'($urandom_range(0, 4000000)), cmns_pkg::CNT_W'(1));
        random_phase(12, SLOTS);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        apply_setting(cmns_pkg::DSQ_W'({$urandom, $urandom}), cmns_pkg::CNT_W'(SLOTS));
        random_phase(18, SLOTS);
        apply_setting(cmns_pkg::DSQ_W'($urandom_range(0, 16000000)),
                      cmns_pkg::CNT_W'($urandom_range(2, SLOTS)));
        random_phase(20, SLOTS);

        s_axis_tvalid <= 1'b0;
        wait_quiet();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("contact_map_neighbor_search_top regression: pass");
        end else begin
            $display("contact_map_neighbor_search_top regression: fail");
        end
        $finish;
    end

    // Far beyond the slowest correct run: every query of the full store
    // with every result held back by the receiver.
    initial begin : watchdog
        #5000000;
        $display("contact_map_neighbor_search_top regression: fail");
        $finish;
    end

endmodule
